/* hw/rtl/bcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge gauge package
// Shared constants, codes and types for the battery charge gauge.
// ----------------------------------------------------------------------------
package bcg_pkg;

    // Default parameter values for the top level.
    localparam int DEFAULT_WINDOW_DEPTH = 64;
    localparam int DEFAULT_SAMPLE_BITS  = 12;

    // Field widths.
    localparam int CELLS_BITS  = 3;
    localparam int PCT_BITS    = 7;
    localparam int MV_BITS     = 14;
    localparam int LEVEL_BITS  = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int M_TDATA_W   = 24;

    // Arithmetic constants.
    localparam int unsigned VALID_ABOVE    = 1000;
    localparam int unsigned MV_SCALE_Q16   = 250655;
    localparam int          MV_SCALE_BITS  = 18;
    localparam int          MV_FRAC_BITS   = 16;
    localparam int unsigned MV_MAX         = 16383;
    localparam int unsigned EMPTY_MV       = 3500;
    localparam int unsigned MV_PER_PERCENT = 7;
    localparam int unsigned PCT_MAX        = 100;
    // Any per-cell excess of this many millivolts or more gives full charge.
    localparam int unsigned PCT_CLAMP_SPAN = PCT_MAX * MV_PER_PERCENT;
    localparam int          PCT_NUM_BITS   = $clog2(PCT_CLAMP_SPAN);
    // Division by seven as a multiply by 2^18 / 7 rounded up and a shift; the
    // quotient is exact for every numerator below PCT_CLAMP_SPAN.
    localparam int unsigned PCT_RECIP       = 37450;
    localparam int          PCT_RECIP_BITS  = 16;
    localparam int          PCT_RECIP_SHIFT = 18;

    // Register reset values.
    localparam logic [CELLS_BITS-1:0] CELLS_RESET    = 3'd3;
    localparam logic [PCT_BITS-1:0]   WARN_RESET     = 7'd30;
    localparam logic [PCT_BITS-1:0]   CRITICAL_RESET = 7'd15;
    localparam logic [PCT_BITS-1:0]   PCT_RESET      = 7'd100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_CELL_COUNT       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WARN_PERCENT     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CRITICAL_PERCENT = 2'd2;

    typedef enum logic [LEVEL_BITS-1:0] {
        LEVEL_NORMAL   = 2'd0,
        LEVEL_LOW      = 2'd1,
        LEVEL_CRITICAL = 2'd2
    } bcg_level_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG,
        ST_MUL,
        ST_SCALE,
        ST_CELL_GO,
        ST_CELL_WAIT,
        ST_PCT,
        ST_LEVEL,
        ST_OUT
    } bcg_state_t;

    // Control handed to every cell of the sample chain.
    typedef struct packed {
        logic load;   // all cells take the same sample
        logic shift;  // every cell takes its neighbour's value, cell 0 the new sample
    } bcg_cell_ctrl_t;

endpackage

/* hw/rtl/bcg_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge gauge sample cell
// One tap of the moving-average delay chain.
// ----------------------------------------------------------------------------
module bcg_cell #(
    parameter int W = 12
) (
    input  logic                    aclk,
    input  bcg_pkg::bcg_cell_ctrl_t ctrl,
    input  logic [W-1:0]            load_data,
    input  logic [W-1:0]            shift_in,
    output logic [W-1:0]            q
);
    import bcg_pkg::*;

    logic [W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            q_reg <= load_data;
        end else if (ctrl.shift) begin
            q_reg <= shift_in;
        end
    end

    assign q = q_reg;

endmodule

/* hw/rtl/bcg_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge gauge divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bcg_div #(
    parameter int W = 18
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    import bcg_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(W);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            quo_next  = {quo_reg[W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* hw/rtl/battery_charge_gauge_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge gauge
// Moving-average pack voltage, charge percent and charge level per tick.
// ----------------------------------------------------------------------------
// Each input request is one evaluation tick carrying an ADC sample and the
// charger pin, and it yields exactly one result request. A sample above 1000
// is shifted into a chain of WINDOW_DEPTH cells (the first such sample fills
// the whole chain) and the running window sum is updated from the oldest
// cell. WINDOW_DEPTH must be a power of two: the average is simply the upper
// bits of the window sum. The per-cell voltage comes from a bit-serial
// divider of DIV_W bits, and the division by seven for the percent is a
// reciprocal multiply. A valid sample passes through ST_AVG, ST_MUL,
// ST_SCALE, ST_CELL_GO, ST_CELL_WAIT, ST_PCT, ST_LEVEL and ST_OUT to a
// loaded result register, and skips ST_PCT when the percent saturates at 0
// or 100. A sample of 1000 or less leaves the window and the held outputs
// untouched and goes straight to ST_OUT. Either kind waits in ST_OUT while
// the previous result still waits in the output register. One tick is worked
// on at a time; the next one is accepted as soon as the previous result sits
// in the output register, even while that result still waits for the
// downstream side. Configuration writes are always accepted and are expected
// only while the block is idle.
// ----------------------------------------------------------------------------
module battery_charge_gauge_top #(
    parameter int WINDOW_DEPTH = bcg_pkg::DEFAULT_WINDOW_DEPTH,
    parameter int SAMPLE_BITS  = bcg_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic aclk,
    input  logic aresetn,

    // Tick input. s_tdata: adc_sample [SAMPLE_BITS-1:0], charger_pin above it.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] s_tdata,

    // Result. m_tdata: pack_millivolts [13:0], charge_percent [20:14],
    // charge_level [22:21], charging [23].
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcg_pkg::M_TDATA_W-1:0]   m_tdata,

    // Register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bcg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bcg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import bcg_pkg::*;

    // The window sum can never exceed WINDOW_DEPTH full-scale samples.
    localparam int AVG_SHIFT  = $clog2(WINDOW_DEPTH);
    localparam int SUM_W      = SAMPLE_BITS + AVG_SHIFT;
    // The divider only ever divides the pack millivolts by the cell count.
    localparam int DIV_W      = MV_BITS;
    localparam int PROD_W     = SAMPLE_BITS + MV_SCALE_BITS;
    localparam int PCT_PROD_W = PCT_NUM_BITS + PCT_RECIP_BITS;

    bcg_state_t               state_reg, state_next;
    logic [CELLS_BITS-1:0]    cells_reg, cells_next;
    logic [PCT_BITS-1:0]      warn_reg, warn_next;
    logic [PCT_BITS-1:0]      crit_reg, crit_next;
    logic                     primed_reg, primed_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic                     charging_reg, charging_next;
    logic [SAMPLE_BITS-1:0]   avg_reg, avg_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [MV_BITS-1:0]       held_mv_reg, held_mv_next;
    logic [PCT_BITS-1:0]      held_pct_reg, held_pct_next;
    bcg_level_t               held_level_reg, held_level_next;
    logic [PCT_NUM_BITS-1:0]  pct_num_reg, pct_num_next;
    logic                     m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]     m_data_reg, m_data_next;

    logic [SAMPLE_BITS-1:0]   s_sample;
    logic                     s_pin;
    logic                     s_accept;
    logic                     sample_ok;
    logic                     accept_invalid;
    logic [CELLS_BITS-1:0]    cells_eff;
    logic [PROD_W-1:0]        mv_wide;
    logic [DIV_W-1:0]         pct_diff;
    logic [PCT_PROD_W-1:0]    pct_prod;

    bcg_cell_ctrl_t           cell_ctrl;
    logic [SAMPLE_BITS-1:0]   chain [WINDOW_DEPTH];
    logic [SAMPLE_BITS-1:0]   tail;

    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIV_W-1:0]         div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_quotient;

    assign s_sample       = s_tdata[SAMPLE_BITS-1:0];
    assign s_pin          = s_tdata[SAMPLE_BITS];
    assign s_accept       = s_tvalid && s_tready;
    assign sample_ok      = 32'(s_sample) > VALID_ABOVE;
    assign accept_invalid = s_accept && !sample_ok;
    assign cells_eff      = (cells_reg == '0) ? CELLS_BITS'(1) : cells_reg;
    assign mv_wide        = prod_reg >> MV_FRAC_BITS;
    assign pct_diff       = div_quotient - DIV_W'(EMPTY_MV);
    assign pct_prod       = PCT_PROD_W'(pct_num_reg) * PCT_PROD_W'(PCT_RECIP);
    assign tail           = chain[WINDOW_DEPTH-1];

    // Delay chain: cell 0 takes the new sample, the last cell holds the
    // sample that leaves the window.
    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_chain
        bcg_cell #(
            .W (SAMPLE_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl),
            .load_data (s_sample),
            .shift_in  ((i == 0) ? s_sample : chain[(i == 0) ? 0 : i - 1]),
            .q         (chain[i])
        );
    end

    bcg_div #(
        .W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Next state and datapath control.
    always_comb begin
        state_next      = state_reg;
        cells_next      = cells_reg;
        warn_next       = warn_reg;
        crit_next       = crit_reg;
        primed_next     = primed_reg;
        sum_next        = sum_reg;
        charging_next   = charging_reg;
        avg_next        = avg_reg;
        prod_next       = prod_reg;
        held_mv_next    = held_mv_reg;
        held_pct_next   = held_pct_reg;
        held_level_next = held_level_reg;
        pct_num_next    = pct_num_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        cell_ctrl       = '0;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        s_tready        = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CELL_COUNT:       cells_next = cfg_data[CELLS_BITS-1:0];
                CFG_WARN_PERCENT:     warn_next  = cfg_data[PCT_BITS-1:0];
                CFG_CRITICAL_PERCENT: crit_next  = cfg_data[PCT_BITS-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    charging_next = s_pin;
                    if (sample_ok) begin
                        cell_ctrl.load  = !primed_reg;
                        cell_ctrl.shift = primed_reg;
                        primed_next     = 1'b1;
                        if (primed_reg) begin
                            sum_next = sum_reg + SUM_W'(s_sample) - SUM_W'(tail);
                        end else begin
                            sum_next = SUM_W'(s_sample) * SUM_W'(WINDOW_DEPTH);
                        end
                        state_next = ST_AVG;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_AVG: begin
                avg_next   = sum_reg[AVG_SHIFT +: SAMPLE_BITS];
                state_next = ST_MUL;
            end
            ST_MUL: begin
                prod_next  = PROD_W'(avg_reg) * PROD_W'(MV_SCALE_Q16);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (mv_wide > PROD_W'(MV_MAX)) begin
                    held_mv_next = MV_BITS'(MV_MAX);
                end else begin
                    held_mv_next = mv_wide[MV_BITS-1:0];
                end
                state_next = ST_CELL_GO;
            end
            ST_CELL_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(held_mv_reg);
                div_divisor  = DIV_W'(cells_eff);
                state_next   = ST_CELL_WAIT;
            end
            ST_CELL_WAIT: begin
                if (div_done) begin
                    if (div_quotient < DIV_W'(EMPTY_MV)) begin
                        held_pct_next = '0;
                        state_next    = ST_LEVEL;
                    end else if (pct_diff >= DIV_W'(PCT_CLAMP_SPAN)) begin
                        held_pct_next = PCT_BITS'(PCT_MAX);
                        state_next    = ST_LEVEL;
                    end else begin
                        pct_num_next = pct_diff[PCT_NUM_BITS-1:0];
                        state_next   = ST_PCT;
                    end
                end
            end
            ST_PCT: begin
                held_pct_next = pct_prod[PCT_RECIP_SHIFT +: PCT_BITS];
                state_next    = ST_LEVEL;
            end
            ST_LEVEL: begin
                if (held_pct_reg > warn_reg) begin
                    held_level_next = LEVEL_NORMAL;
                end else if (held_pct_reg > crit_reg) begin
                    held_level_next = LEVEL_LOW;
                end else begin
                    held_level_next = LEVEL_CRITICAL;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {charging_reg, held_level_reg, held_pct_reg, held_mv_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        avg_reg     <= avg_next;
        prod_reg    <= prod_next;
        pct_num_reg <= pct_num_next;
        m_data_reg  <= m_data_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cells_reg      <= CELLS_RESET;
            warn_reg       <= WARN_RESET;
            crit_reg       <= CRITICAL_RESET;
            primed_reg     <= 1'b0;
            sum_reg        <= '0;
            charging_reg   <= 1'b0;
            held_mv_reg    <= '0;
            held_pct_reg   <= PCT_RESET;
            held_level_reg <= LEVEL_NORMAL;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cells_reg      <= cells_next;
            warn_reg       <= warn_next;
            crit_reg       <= crit_next;
            primed_reg     <= primed_next;
            sum_reg        <= sum_next;
            charging_reg   <= charging_next;
            held_mv_reg    <= held_mv_next;
            held_pct_reg   <= held_pct_next;
            held_level_reg <= held_level_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

    // The average is taken from the upper bits of the sum, so the window
    // length has to be a power of two.
    a_depth_pow2: assert property (@(posedge aclk)
        (WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0)
        else $error("window depth is not a power of two");

    // The divider only finishes while the sequencer is waiting for it.
    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_CELL_WAIT))
        else $error("divider finished outside a wait state");

    // The held percent never leaves its clamped range.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_pct_reg <= PCT_BITS'(PCT_MAX))
        else $error("held percent above full charge");

    // Once the window has been primed it stays primed.
    a_primed_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg)
        else $error("window lost its primed state");

    // A rejected sample goes straight to the result and leaves the window alone.
    a_invalid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_invalid |=> (state_reg == ST_OUT) && $stable(sum_reg) &&
                           $stable(held_mv_reg))
        else $error("invalid sample disturbed the window");

endmodule
